// ----- rtl/core/cgfs_pkg.sv -----
// Shared types and constants for the centered Gaussian FIR smoother.
package cgfs_pkg;

	localparam int MAX_TAPS_DEF   = 64;
	localparam int MAX_LENGTH_DEF = 1048576;

	localparam int SAMPLE_W  = 32;
	localparam int TAP_W     = 16;
	localparam int TAP_IDX_W = 6;
	localparam int OUT_IDX_W = 20;
	localparam int SIGMA_W   = 4;
	localparam int NTAPS_W   = 6;
	localparam int HALF_W    = 5;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = SAMPLE_W + TAP_W;

	localparam int TAPS_PER_SIGMA = 6;
	localparam int HALF_PER_SIGMA = TAPS_PER_SIGMA / 2;
	localparam int SIGMA_MIN      = 1;
	localparam int SIGMA_MAX      = 10;
	localparam int SIGMA_RESET    = 1;
	localparam int ROUND_HALF     = 1 << (FRAC_W - 1);

	localparam logic signed [SAMPLE_W-1:0] SMOOTH_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] SMOOTH_MIN = 32'sh8000_0000;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_TAP    = 1'b1
	} cmd_t;

	// control broadcast to every cell of the tap chain
	typedef struct packed {
		logic                 adv;
		logic                 shift;
		logic                 clear;
		logic                 tap_we;
		logic [TAP_IDX_W-1:0] tap_index;
		logic [TAP_W-1:0]     tap_value;
		logic [NTAPS_W-1:0]   n_taps;
	} cell_ctrl_t;

	// travels with each step down the pipeline
	typedef struct packed {
		logic                 emit;
		logic [OUT_IDX_W-1:0] idx;
		logic                 fin;
	} tag_t;

endpackage

// ----- rtl/core/cgfs_if.sv -----
// Input and result channel interfaces of the smoother.
interface cgfs_in_if;
	import cgfs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [TAP_IDX_W-1:0] tap_index;
	logic [TAP_W-1:0]     tap_value;
	logic [SAMPLE_W-1:0]  sample;
	logic                 last;
	modport source (output valid, command, tap_index, tap_value, sample, last, input ready);
	modport sink   (input valid, command, tap_index, tap_value, sample, last, output ready);
endinterface

interface cgfs_out_if;
	import cgfs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OUT_IDX_W-1:0] out_index;
	logic [SAMPLE_W-1:0]  smoothed;
	logic                 final_res;
	modport source (output valid, out_index, smoothed, final_res, input ready);
	modport sink   (input valid, out_index, smoothed, final_res, output ready);
endinterface

// ----- rtl/core/cgfs_cell.sv -----
// One cell of the tap chain: a history entry, its tap and their product.
module cgfs_cell #(
	parameter int INDEX = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cgfs_pkg::cell_ctrl_t                  ctrl,
	input  logic signed [cgfs_pkg::SAMPLE_W-1:0] hist_in,
	output logic signed [cgfs_pkg::SAMPLE_W-1:0] hist,
	output logic signed [cgfs_pkg::PROD_W-1:0]   prod
);
	import cgfs_pkg::*;

	logic signed [SAMPLE_W-1:0] hist_q;
	logic [TAP_W-1:0]           tap_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [PROD_W-1:0]   mul;
	logic                       active;

	assign active = int'(ctrl.n_taps) > INDEX;
	assign mul    = PROD_W'(hist_q) * PROD_W'($signed({1'b0, tap_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			tap_q  <= '0;
		end else if (ctrl.adv) begin
			if (ctrl.clear) begin
				hist_q <= '0;
			end else if (ctrl.shift) begin
				hist_q <= hist_in;
			end
			if (ctrl.tap_we && int'(ctrl.tap_index) == INDEX) begin
				tap_q <= ctrl.tap_value;
			end
		end
	end

	// product of the state left by the previous step
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			prod_s1 <= active ? mul : '0;
		end
	end

	assign hist = hist_q;
	assign prod = prod_s1;

endmodule

// ----- rtl/core/cgfs_adder_tree.sv -----
// Registered binary adder tree over the cell products, with a matching tag delay.
module cgfs_adder_tree #(
	parameter int N = cgfs_pkg::MAX_TAPS_DEF,
	parameter int W = cgfs_pkg::PROD_W
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic signed [W-1:0]                  leaf [N],
	input  cgfs_pkg::tag_t                       tag_in,
	output logic signed [W+$clog2(N)-1:0]        sum,
	output cgfs_pkg::tag_t                       tag_out
);
	import cgfs_pkg::*;

	localparam int LV = $clog2(N);
	localparam int P  = 1 << LV;
	localparam int SW = W + LV;

	logic signed [SW-1:0] leaf_ext [P];
	// heap order: node 0 is the root, children of i are 2i+1 and 2i+2
	logic signed [SW-1:0] node_q [P-1];
	tag_t                 tag_q [LV];

	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_used
			assign leaf_ext[i] = SW'(leaf[i]);
		end else begin : g_pad
			assign leaf_ext[i] = '0;
		end
	end

	for (genvar i = 0; i < P - 1; i++) begin : g_node
		if (2 * i + 1 >= P - 1) begin : g_bottom
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[i] <= leaf_ext[2*i+1-(P-1)] + leaf_ext[2*i+2-(P-1)];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[i] <= node_q[2*i+1] + node_q[2*i+2];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LV; k++) begin
				tag_q[k] <= '0;
			end
		end else if (en) begin
			tag_q[0] <= tag_in;
			for (int k = 1; k < LV; k++) begin
				tag_q[k] <= tag_q[k-1];
			end
		end
	end

	assign sum     = node_q[0];
	assign tag_out = tag_q[LV-1];

endmodule

// ----- rtl/core/centered_gaussian_fir_smoother_core.sv -----
// Top level of the centered Gaussian FIR smoother: control, tap chain, tree, output stage.
// Takes one beat per clock while the result is not stalled and no flush or clear runs:
// tap loads (command 1) write the tap held in one cell, samples (command 0) shift the
// history chain. A result passes the history register, the per-cell product register,
// one register per adder tree level and the round-and-saturate output register. The
// last sample of a signal is followed by flush steps, which shift zeros down the chain
// and emit the tail outputs, and by a step that clears the history; no beat is taken
// during those. The whole chain advances only when the result register is empty or
// being taken, so a stalled result stalls the input side too.
module centered_gaussian_fir_smoother_core #(
	parameter int MAX_TAPS   = cgfs_pkg::MAX_TAPS_DEF,
	parameter int MAX_LENGTH = cgfs_pkg::MAX_LENGTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cgfs_pkg::SIGMA_W-1:0] cfg_wdata,
	cgfs_in_if.sink                      feed,
	cgfs_out_if.source                   result
);
	import cgfs_pkg::*;

	localparam int CW   = $clog2(MAX_LENGTH);
	localparam int JW   = ((CW > HALF_W) ? CW : HALF_W) + 1;
	localparam int SLIM = MAX_TAPS / TAPS_PER_SIGMA;
	localparam int SMAX = (SLIM < SIGMA_MAX) ? SLIM : SIGMA_MAX;
	localparam int LV   = $clog2(MAX_TAPS);
	localparam int SW   = PROD_W + LV;
	localparam int RW   = SW + 1;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_CLEAR
	} st_t;

	st_t                  state_q;
	logic [SIGMA_W-1:0]   sigma_q;
	logic [CW-1:0]        count_q;
	logic [JW-1:0]        j_q;
	logic [CW-1:0]        jend_q;
	tag_t                 step_tag_s0;
	tag_t                 tag_s1;

	logic [SIGMA_W-1:0]   s_clip;
	logic [SIGMA_W-1:0]   s_eff;
	logic [NTAPS_W-1:0]   n_taps;
	logic [HALF_W-1:0]    k3m1;

	logic                 adv;
	logic                 take;
	logic                 is_sample;
	logic                 tap_we;
	logic                 fin;
	logic                 run_emit;
	logic [OUT_IDX_W-1:0] run_idx;
	logic [JW-1:0]        j_start;
	logic                 flush_emit;
	logic                 flush_final;
	tag_t                 step_tag;

	cell_ctrl_t                 cell_ctrl;
	logic signed [SAMPLE_W-1:0] chain_in;
	logic signed [SAMPLE_W-1:0] hist_w [MAX_TAPS];
	logic signed [PROD_W-1:0]   prod_w [MAX_TAPS];

	logic signed [SW-1:0]       root_sum;
	tag_t                       root_tag;
	logic signed [RW-1:0]       rnd;
	logic signed [RW-1:0]       quo;
	logic signed [SAMPLE_W-1:0] sat;

	logic                       out_valid_q;
	logic [OUT_IDX_W-1:0]       out_idx_q;
	logic [SAMPLE_W-1:0]        out_val_q;
	logic                       out_fin_q;

	// effective sigma and kernel geometry
	always_comb begin
		if (sigma_q < SIGMA_W'(SIGMA_MIN)) begin
			s_clip = SIGMA_W'(SIGMA_MIN);
		end else if (sigma_q > SIGMA_W'(SIGMA_MAX)) begin
			s_clip = SIGMA_W'(SIGMA_MAX);
		end else begin
			s_clip = sigma_q;
		end
		s_eff = (s_clip > SIGMA_W'(SMAX)) ? SIGMA_W'(SMAX) : s_clip;
	end

	assign n_taps = NTAPS_W'(NTAPS_W'(s_eff) * NTAPS_W'(TAPS_PER_SIGMA));
	assign k3m1   = HALF_W'(HALF_W'(s_eff) * HALF_W'(HALF_PER_SIGMA)) - HALF_W'(1);

	// handshake
	assign adv       = !out_valid_q || result.ready;
	assign feed.ready = adv && (state_q == ST_RUN);
	assign take      = feed.valid && feed.ready;
	assign is_sample = take && (feed.command == CMD_SAMPLE);
	assign tap_we    = take && (feed.command == CMD_TAP);

	assign fin      = feed.last || (count_q == CW'(MAX_LENGTH - 1));
	assign run_emit = JW'(count_q) >= JW'(k3m1);
	assign run_idx  = OUT_IDX_W'(count_q - CW'(k3m1));
	assign j_start  = JW'(count_q) - JW'(k3m1) + JW'(1);

	assign flush_emit  = !j_q[JW-1];
	assign flush_final = (j_q == JW'(jend_q));

	always_comb begin
		step_tag = '0;
		if (is_sample) begin
			step_tag.emit = run_emit;
			step_tag.idx  = run_idx;
		end else if (state_q == ST_FLUSH) begin
			step_tag.emit = flush_emit;
			step_tag.idx  = OUT_IDX_W'(j_q);
			step_tag.fin  = flush_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_W'(SIGMA_RESET);
		end else if (cfg_we) begin
			sigma_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			count_q     <= '0;
			j_q         <= '0;
			jend_q      <= '0;
			step_tag_s0 <= '0;
			tag_s1      <= '0;
		end else if (adv) begin
			step_tag_s0 <= step_tag;
			tag_s1      <= step_tag_s0;
			unique case (state_q)
				ST_RUN: begin
					if (is_sample) begin
						if (fin) begin
							count_q <= '0;
							j_q     <= j_start;
							jend_q  <= count_q;
							state_q <= ST_FLUSH;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (flush_final) begin
						state_q <= ST_CLEAR;
					end else begin
						j_q <= j_q + JW'(1);
					end
				end
				ST_CLEAR: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// tap chain; flush steps push zeros, which is the zero padding past the end
	assign chain_in = (state_q == ST_FLUSH) ? '0 : $signed(feed.sample);

	always_comb begin
		cell_ctrl           = '0;
		cell_ctrl.adv       = adv;
		cell_ctrl.shift     = is_sample || (state_q == ST_FLUSH);
		cell_ctrl.clear     = (state_q == ST_CLEAR);
		cell_ctrl.tap_we    = tap_we;
		cell_ctrl.tap_index = feed.tap_index;
		cell_ctrl.tap_value = feed.tap_value;
		cell_ctrl.n_taps    = n_taps;
	end

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		cgfs_cell #(
			.INDEX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.hist_in ((k == 0) ? chain_in : hist_w[(k == 0) ? 0 : k - 1]),
			.hist    (hist_w[k]),
			.prod    (prod_w[k])
		);
	end

	cgfs_adder_tree #(
		.N (MAX_TAPS),
		.W (PROD_W)
	) u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.leaf    (prod_w),
		.tag_in  (tag_s1),
		.sum     (root_sum),
		.tag_out (root_tag)
	);

	// round half up, dropping the 16 fraction bits of the Q0.16 taps, to a 32-bit signed sample, then saturate
	assign rnd = RW'(root_sum) + RW'(ROUND_HALF);
	assign quo = rnd >>> FRAC_W;

	always_comb begin
		if (quo > RW'(SMOOTH_MAX)) begin
			sat = SMOOTH_MAX;
		end else if (quo < RW'(SMOOTH_MIN)) begin
			sat = SMOOTH_MIN;
		end else begin
			sat = SAMPLE_W'(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= root_tag.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q <= root_tag.idx;
			out_val_q <= sat;
			out_fin_q <= root_tag.fin;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_index = out_idx_q;
	assign result.smoothed  = out_val_q;
	assign result.final_res = out_fin_q;

	a_fin_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(is_sample && fin) |=> (state_q == ST_FLUSH))
		else $error("last sample did not start the flush");

	a_flush_to_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && state_q == ST_FLUSH && flush_final) |=> (state_q == ST_CLEAR))
		else $error("flush did not end in a history clear");

	a_flush_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && !j_q[JW-1]) |-> (j_q <= JW'(jend_q)))
		else $error("flush index ran past the last sample");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(tag_s1) && $stable(count_q) && $stable(state_q)))
		else $error("pipeline moved while the result was stalled");

	a_no_beat_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH || state_q == ST_CLEAR) |-> !take)
		else $error("beat taken during flush or clear");

endmodule
